FILE: src/mcst_pkg.sv
`timescale 1ns / 1ps
package mcst_pkg;

  // width of the bit timer and of the stored bit period
  localparam int PERIOD_WIDTH = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_FIRST   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_SECOND  = 2'd2;

  localparam int unsigned BIT_PERIOD_RESET = 104;
  localparam logic [7:0]  BRAKE_FIRST_RESET  = 8'd134;
  localparam logic [7:0]  BRAKE_SECOND_RESET = 8'd135;

  localparam logic [7:0] SPEED_OPCODE_BASE = 8'h88;
  localparam logic [7:0] DIR_FLAG          = 8'h02;
  localparam logic [7:0] MOTOR1_FLAG       = 8'h04;
  localparam logic [7:0] VALUE_MAX         = 8'd127;

  // slot 0 is the start bit, 1..8 data, 9 stop
  localparam logic [3:0] STOP_SLOT = 4'd9;

  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_BRAKE = 1'b1;

  typedef struct packed {
    logic              cmd_valid;
    logic              kind;
    logic              motor;
    logic signed [7:0] speed;
    logic [7:0]        strength;
  } in_item_t;

  typedef struct packed {
    logic tx_line;
    logic ready_res;
    logic accepted;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] bit_period;
    logic [7:0]              brake_first;
    logic [7:0]              brake_second;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] value;
  } cmd_bytes_t;

endpackage

FILE: src/motor_command_serial_transmitter_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | in_data   (one timer tick, maybe a command)
// out_    | output    | out_valid / out_ready | out_data  (line level, ready, taken)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per clock while in_ready is high: each accepted tick is encoded and
// stepped through the bit timer combinationally, and its result is registered
// into a two-entry output buffer
// in_ready drops only when both buffer entries hold unread results
// cfg_ready is always high; writes take effect on the next accepted item
// reset (rst_n low, synchronous) returns the line to idle high and clears
// the buffer
module motor_command_serial_transmitter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mcst_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mcst_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mcst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcst_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcst_pkg::*;

  cfg_regs_t  cfg_r;
  cmd_bytes_t bytes;
  out_item_t  result;
  logic       in_fire;

  // configuration registers, written at any time the port handshakes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period   <= PERIOD_WIDTH'(BIT_PERIOD_RESET);
      cfg_r.brake_first  <= BRAKE_FIRST_RESET;
      cfg_r.brake_second <= BRAKE_SECOND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIT_PERIOD:   cfg_r.bit_period   <= PERIOD_WIDTH'(cfg_data);
        CFG_BRAKE_FIRST:  cfg_r.brake_first  <= cfg_data[7:0];
        CFG_BRAKE_SECOND: cfg_r.brake_second <= cfg_data[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // timer state advances only on accepted ticks
  assign in_fire = in_valid && in_ready;

  // opcode and value byte for a command on this tick
  mcst_cmd_encode u_encode (
    .item  (in_data),
    .cfg   (cfg_r),
    .bytes (bytes)
  );

  // frame sequencer: start, 8 data lsb first, stop, twice
  mcst_tx_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (in_data),
    .bytes   (bytes),
    .cfg     (cfg_r),
    .result  (result)
  );

  // result register plus skid entry so a stalled reader does not stop intake at once
  mcst_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (result),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_data)
  );

endmodule

FILE: src/mcst_cmd_encode.sv
`timescale 1ns / 1ps
module mcst_cmd_encode (
  input  mcst_pkg::in_item_t   item,
  input  mcst_pkg::cfg_regs_t  cfg,
  output mcst_pkg::cmd_bytes_t bytes
);
  import mcst_pkg::*;

  logic       negative;
  logic       dir;
  logic [8:0] mag;
  logic [7:0] speed_val;
  logic [7:0] brake_val;

  always_comb begin
    negative  = item.speed[7];
    // magnitude; minus 128 comes out as 128 and is clipped below
    mag       = negative ? (9'd256 - {1'b0, item.speed}) : {1'b0, item.speed};
    speed_val = (mag > {1'b0, VALUE_MAX}) ? VALUE_MAX : mag[7:0];
    brake_val = (item.strength > VALUE_MAX) ? VALUE_MAX : item.strength;
    // motor 1 is mounted mirrored
    dir       = negative ^ item.motor;
    if (item.kind == KIND_SPEED) begin
      bytes.opcode = SPEED_OPCODE_BASE | (dir ? DIR_FLAG : 8'h00)
                   | (item.motor ? MOTOR1_FLAG : 8'h00);
      bytes.value  = speed_val;
    end else begin
      bytes.opcode = item.motor ? cfg.brake_second : cfg.brake_first;
      bytes.value  = brake_val;
    end
  end

endmodule

FILE: src/mcst_tx_engine.sv
`timescale 1ns / 1ps
module mcst_tx_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  mcst_pkg::in_item_t   item,
  input  mcst_pkg::cmd_bytes_t bytes,
  input  mcst_pkg::cfg_regs_t  cfg,
  output mcst_pkg::out_item_t  result
);
  import mcst_pkg::*;

  logic [PERIOD_WIDTH-1:0] tick_r, tick_nxt;
  logic [3:0]              slot_r, slot_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [7:0]              second_r, second_nxt;
  logic                    pending_r, pending_nxt;
  logic                    busy_r, busy_nxt;

  // state after a possible command take
  logic [PERIOD_WIDTH-1:0] tick_b;
  logic [3:0]              slot_b;
  logic [7:0]              shift_b;
  logic [7:0]              second_b;
  logic                    pending_b;
  logic                    busy_b;
  logic                    take;

  logic [PERIOD_WIDTH-1:0] period;
  logic [PERIOD_WIDTH-1:0] tick_inc;
  logic [3:0]              slot_inc;
  logic [2:0]              data_idx;
  logic                    level;

  always_comb begin
    take      = !busy_r && item.cmd_valid;
    tick_b    = take ? '0 : tick_r;
    slot_b    = take ? 4'd0 : slot_r;
    shift_b   = take ? bytes.opcode : shift_r;
    second_b  = take ? bytes.value : second_r;
    pending_b = take ? 1'b1 : pending_r;
    busy_b    = take ? 1'b1 : busy_r;

    period    = (cfg.bit_period == '0) ? PERIOD_WIDTH'(1) : cfg.bit_period;
    tick_inc  = tick_b + PERIOD_WIDTH'(1);
    slot_inc  = slot_b + 4'd1;
    data_idx  = 3'(slot_b - 4'd1);

    if (slot_b == 4'd0) begin
      level = 1'b0;
    end else if (slot_b >= STOP_SLOT) begin
      level = 1'b1;
    end else begin
      level = shift_b[data_idx];
    end

    tick_nxt    = tick_b;
    slot_nxt    = slot_b;
    shift_nxt   = shift_b;
    second_nxt  = second_b;
    pending_nxt = pending_b;
    busy_nxt    = busy_b;

    if (busy_b) begin
      if (tick_inc >= period || tick_inc == '0) begin
        tick_nxt = '0;
        if (slot_inc > STOP_SLOT) begin
          slot_nxt = 4'd0;
          if (pending_b) begin
            shift_nxt   = second_b;
            pending_nxt = 1'b0;
          end else begin
            busy_nxt = 1'b0;
          end
        end else begin
          slot_nxt = slot_inc;
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    result.tx_line   = busy_b ? level : 1'b1;
    result.ready_res = !busy_r;
    result.accepted  = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      slot_r    <= 4'd0;
      shift_r   <= 8'd0;
      second_r  <= 8'd0;
      pending_r <= 1'b0;
      busy_r    <= 1'b0;
    end else if (step_en) begin
      tick_r    <= tick_nxt;
      slot_r    <= slot_nxt;
      shift_r   <= shift_nxt;
      second_r  <= second_nxt;
      pending_r <= pending_nxt;
      busy_r    <= busy_nxt;
    end
  end

endmodule

FILE: src/mcst_out_buf.sv
`timescale 1ns / 1ps
module mcst_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  mcst_pkg::out_item_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output mcst_pkg::out_item_t rd_data
);
  import mcst_pkg::*;

  out_item_t main_r, skid_r;
  logic      main_v_r, skid_v_r;
  logic      wr_fire;

  assign wr_ready = !skid_v_r;
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_valid = main_v_r;
  assign rd_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || rd_ready) begin
      main_v_r <= skid_v_r || wr_fire;
      skid_v_r <= 1'b0;
    end else if (wr_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || rd_ready) begin
      main_r <= skid_v_r ? skid_r : wr_data;
    end else if (wr_fire) begin
      skid_r <= wr_data;
    end
  end

endmodule

FILE: src/mcst_checker.sv
`timescale 1ns / 1ps
module mcst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mcst_pkg::out_item_t out_data
);
  import mcst_pkg::*;

  // nothing left in the buffer after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a command is only taken while idle
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.ready_res)
    else $error("command taken while busy");

  // the start bit begins on the taking tick
  a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.tx_line)
    else $error("no start bit on taking tick");

  // idle without a command keeps the line high
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ready_res && !out_data.accepted |-> out_data.tx_line)
    else $error("line low while idle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind motor_command_serial_transmitter_core mcst_checker u_mcst_checker (.*);

FILE: tb/mcst_line_checker.sv
`timescale 1ns / 1ps
module mcst_line_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  mcst_pkg::in_item_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  mcst_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mcst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcst_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending,
  output int                               errors
);
  import mcst_pkg::*;

  // register copies
  logic [PERIOD_WIDTH-1:0] period_reg;
  logic [7:0]              brake_op0;
  logic [7:0]              brake_op1;

  // line state
  logic [PERIOD_WIDTH-1:0] timer_cnt;
  logic [3:0]              slot;
  logic [7:0]              tx_byte;
  logic [7:0]              held_value;
  logic                    value_waiting;
  logic                    sending;
  logic                    level;

  out_item_t line_q[$];

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void clear_line();
    period_reg    = PERIOD_WIDTH'(BIT_PERIOD_RESET);
    brake_op0     = BRAKE_FIRST_RESET;
    brake_op1     = BRAKE_SECOND_RESET;
    timer_cnt     = '0;
    slot          = '0;
    tx_byte       = '0;
    held_value    = '0;
    value_waiting = 1'b0;
    sending       = 1'b0;
    level         = 1'b1;
  endfunction

  // one timer tick: maybe take a command, then move the line on by one tick
  function automatic out_item_t advance_line(input in_item_t tick);
    out_item_t               r;
    logic [7:0]              op;
    logic [7:0]              mag;
    logic                    dir;
    logic [PERIOD_WIDTH-1:0] span;
    r.ready_res = !sending;
    r.accepted  = 1'b0;
    if (!sending && tick.cmd_valid) begin
      if (tick.kind == KIND_SPEED) begin
        // motor 1 is mounted mirrored, so its direction flips
        dir = tick.speed[7] ^ tick.motor;
        mag = tick.speed[7] ? (~tick.speed + 8'd1) : tick.speed;
        if (mag > VALUE_MAX) mag = VALUE_MAX;
        op = SPEED_OPCODE_BASE | (dir ? DIR_FLAG : 8'h00)
             | (tick.motor ? MOTOR1_FLAG : 8'h00);
      end else begin
        op  = tick.motor ? brake_op1 : brake_op0;
        mag = (tick.strength > VALUE_MAX) ? VALUE_MAX : tick.strength;
      end
      tx_byte       = op;
      held_value    = mag;
      value_waiting = 1'b1;
      sending       = 1'b1;
      slot          = '0;
      timer_cnt     = '0;
      r.accepted    = 1'b1;
    end
    if (sending) begin
      if (slot == 4'd0) level = 1'b0;
      else if (slot >= STOP_SLOT) level = 1'b1;
      else level = tx_byte[3'(slot - 4'd1)];
      span      = (period_reg == '0) ? PERIOD_WIDTH'(1) : period_reg;
      timer_cnt = timer_cnt + 1'b1;
      if (timer_cnt >= span || timer_cnt == '0) begin
        timer_cnt = '0;
        slot      = slot + 4'd1;
        if (slot > STOP_SLOT) begin
          slot = '0;
          if (value_waiting) begin
            tx_byte       = held_value;
            value_waiting = 1'b0;
          end else begin
            sending = 1'b0;
          end
        end
      end
    end else begin
      level = 1'b1;
    end
    r.tx_line = level;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      clear_line();
      line_q.delete();
    end else begin
      // results first: a result never belongs to the item taken at this edge
      if (out_valid && out_ready) begin
        if (line_q.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          exp_item = line_q.pop_front();
          if (out_data.tx_line !== exp_item.tx_line)
            report_mismatch($sformatf("tx_line got %b want %b",
                                      out_data.tx_line, exp_item.tx_line));
          if (out_data.ready_res !== exp_item.ready_res)
            report_mismatch($sformatf("ready_res got %b want %b",
                                      out_data.ready_res, exp_item.ready_res));
          if (out_data.accepted !== exp_item.accepted)
            report_mismatch($sformatf("accepted got %b want %b",
                                      out_data.accepted, exp_item.accepted));
        end
      end
      // an item taken at this edge still sees the old register values
      if (in_valid && in_ready) line_q.push_back(advance_line(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIT_PERIOD:   period_reg = cfg_data[PERIOD_WIDTH-1:0];
          CFG_BRAKE_FIRST:  brake_op0  = cfg_data[7:0];
          CFG_BRAKE_SECOND: brake_op1  = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending = line_q.size();
  end

endmodule

FILE: tb/tb_motor_command_serial_transmitter_core.sv
`timescale 1ns / 1ps
module tb_motor_command_serial_transmitter_core;
  import mcst_pkg::*;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int pending;
  int errors;

  // knobs shared by the sender and the receiver processes
  int gap_pct     = 0;
  int stall_pct   = 0;
  bit pressure_on = 1'b0;

  motor_command_serial_transmitter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watches all three channels, predicts every result and counts mismatches
  mcst_line_checker line_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs while pressure is on so the
  // two-entry output buffer fills and in_ready has to drop
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (pressure_on && $urandom_range(9) == 0) begin
        hold = 40 + $urandom_range(60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one timer tick, command bit and fields all random
  function automatic in_item_t random_tick(input int cmd_pct);
    in_item_t t;
    t.cmd_valid = ($urandom_range(99) < cmd_pct);
    t.kind      = 1'($urandom_range(1));
    t.motor     = 1'($urandom_range(1));
    t.speed     = 8'($urandom);
    t.strength  = 8'($urandom);
    return t;
  endfunction

  function automatic in_item_t make_cmd(input logic kind, input logic motor,
                                        input logic signed [7:0] speed,
                                        input logic [7:0] strength);
    in_item_t t;
    t.cmd_valid = 1'b1;
    t.kind      = kind;
    t.motor     = motor;
    t.speed     = speed;
    t.strength  = strength;
    return t;
  endfunction

  // offer one item, with optional idle cycles ahead of it, and hold it
  // until the block takes it
  task automatic send_tick(input in_item_t tick);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pad_ticks(input int n, input int cmd_pct);
    repeat (n) send_tick(random_tick(cmd_pct));
  endtask

  // directed command followed by enough ticks for both frames at a one-tick
  // bit period; the padding ticks all carry commands, which must be dropped
  task automatic directed_cmd(input logic kind, input logic motor,
                              input logic signed [7:0] speed,
                              input logic [7:0] strength);
    send_tick(make_cmd(kind, motor, speed, strength));
    pad_ticks(19, 100);
  endtask

  // stop offering and wait until every result has been read back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] period,
                          input logic [7:0] brake0, input logic [7:0] brake1);
    // upper data bits are junk for the byte-wide registers
    write_reg(CFG_BIT_PERIOD, period);
    write_reg(CFG_BRAKE_FIRST, {8'($urandom), brake0});
    write_reg(CFG_BRAKE_SECOND, {8'($urandom), brake1});
  endtask

  task automatic run_phase(input int n, input int gap, input int stall,
                           input int cmd_pct);
    gap_pct   = gap;
    stall_pct = stall;
    pad_ticks(n, cmd_pct);
    settle();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values: brake on motor 0 at 104 ticks per bit runs
    // through its start bit into the first data bit
    send_tick(make_cmd(KIND_BRAKE, 1'b0, 8'sd0, 8'd200));
    pad_ticks(110, 50);
    settle();
    // the period shrinks under the frame in flight, which then drains
    write_reg(CFG_BIT_PERIOD, 16'd1);
    pad_ticks(25, 0);
    // brake on motor 1 with its opcode still at the reset value
    directed_cmd(KIND_BRAKE, 1'b1, 8'sd0, 8'd50);
    settle();

    // directed commands, zero bit period acting as one, extreme brake opcodes
    set_regs(16'd0, 8'h00, 8'hFF);
    directed_cmd(KIND_SPEED, 1'b0, 8'sd0, 8'd0);
    directed_cmd(KIND_SPEED, 1'b0, 8'sd127, 8'd0);
    directed_cmd(KIND_SPEED, 1'b0, -8'sd1, 8'd0);
    directed_cmd(KIND_SPEED, 1'b0, -8'sd128, 8'd0);
    directed_cmd(KIND_SPEED, 1'b1, 8'sd5, 8'd0);
    directed_cmd(KIND_SPEED, 1'b1, -8'sd128, 8'd0);
    directed_cmd(KIND_SPEED, 1'b1, -8'sd127, 8'd255);
    directed_cmd(KIND_BRAKE, 1'b0, -8'sd1, 8'd0);
    directed_cmd(KIND_BRAKE, 1'b0, 8'sd0, 8'd127);
    directed_cmd(KIND_BRAKE, 1'b1, 8'sd0, 8'd128);
    directed_cmd(KIND_BRAKE, 1'b1, 8'sd0, 8'd255);
    settle();

    // random phases, one per idling pattern
    set_regs(16'd1, 8'($urandom), 8'($urandom));
    run_phase(40, 0, 0, 30);
    set_regs(16'd2, 8'($urandom), 8'($urandom));
    run_phase(40, 68, 0, 30);
    set_regs(16'd3, 8'($urandom), 8'($urandom));
    run_phase(40, 0, 68, 30);
    set_regs(16'd0, 8'($urandom), 8'($urandom));
    run_phase(40, 33, 33, 30);

    // widest bit period: the frame stays in its start bit, then the period
    // shrinks under a frame in flight
    set_regs(16'hFFFF, 8'hFF, 8'h00);
    run_phase(40, 0, 0, 50);
    // unused register index, must change nothing
    write_reg(CFG_INDEX_W'(3), 16'($urandom));

    // back-pressure: receiver holds off for long stretches, sender never idles
    set_regs(16'd1, 8'($urandom), 8'($urandom));
    pressure_on = 1'b1;
    run_phase(80, 0, 0, 40);
    pressure_on = 1'b0;

    repeat (2) begin
      set_regs(16'($urandom_range(6, 1)), 8'($urandom), 8'($urandom));
      run_phase(40, 33 * $urandom_range(2), 33 * $urandom_range(2), 30);
    end

    // wait past the output buffer so that stray results are caught
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("motor_command_serial_transmitter_core test passed");
    end else begin
      $display("motor_command_serial_transmitter_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("motor_command_serial_transmitter_core test failed");
    $finish;
  end

endmodule

FILE: motor_command_serial_transmitter_core.f
src/mcst_pkg.sv
src/mcst_cmd_encode.sv
src/mcst_tx_engine.sv
src/mcst_out_buf.sv
src/motor_command_serial_transmitter_core.sv
src/mcst_checker.sv
tb/mcst_line_checker.sv
tb/tb_motor_command_serial_transmitter_core.sv
